>>> design/tcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle rasterizer package
// Shared widths, command codes and the walker state type.
// ----------------------------------------------------------------------------
package tcr_pkg;

	localparam int RADIUS_BITS = 10;
	localparam int BRUSH_BITS  = 4;

	localparam int CENTER_W = 12;
	localparam int COORD_W  = 13;
	localparam int COLOR_W  = 8;
	localparam int ALPHA_W  = 8;
	localparam int RADIUS_W = 10;
	localparam int BRUSH_W  = 4;

	localparam int STEP_W = RADIUS_BITS + 1;
	localparam int OFS_W  = BRUSH_BITS + 1;
	localparam int DEC_W  = RADIUS_BITS + 6;
	localparam int SUM_W  = (STEP_W + 2 > COORD_W + 1) ? STEP_W + 2 : COORD_W + 1;

	localparam logic [ALPHA_W-1:0] OPACITY_RESET = 8'd255;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef struct packed {
		logic        [STEP_W-1:0]   step_x;
		logic        [STEP_W-1:0]   step_y;
		logic signed [OFS_W-1:0]    offset_i;
		logic signed [OFS_W-1:0]    offset_j;
		logic        [2:0]          octant;
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
	} walk_state_t;

endpackage

>>> design/tcr_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle rasterizer channels
// Valid/ready channels for command items and for emitted pixels.
// ----------------------------------------------------------------------------
interface tcr_item_if import tcr_pkg::*; ;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic signed [CENTER_W-1:0] center_x;
	logic signed [CENTER_W-1:0] center_y;
	logic        [RADIUS_W-1:0] radius;
	logic        [BRUSH_W-1:0]  brush_half;
	logic        [COLOR_W-1:0]  color_r;
	logic        [COLOR_W-1:0]  color_g;
	logic        [COLOR_W-1:0]  color_b;

	modport source (output valid, cmd, center_x, center_y, radius, brush_half,
		color_r, color_g, color_b, input ready);
	modport sink (input valid, cmd, center_x, center_y, radius, brush_half,
		color_r, color_g, color_b, output ready);
endinterface

interface tcr_pixel_if import tcr_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pixel_x;
	logic signed [COORD_W-1:0] pixel_y;
	logic        [COLOR_W-1:0] pix_r;
	logic        [COLOR_W-1:0] pix_g;
	logic        [COLOR_W-1:0] pix_b;
	logic        [ALPHA_W-1:0] pix_alpha;
	logic                      last;

	modport source (output valid, pixel_x, pixel_y, pix_r, pix_g, pix_b, pix_alpha,
		last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pix_r, pix_g, pix_b, pix_alpha,
		last, output ready);
endinterface

>>> design/tcr_pixel_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle rasterizer pixel position
// Mirrors the current step into its octant and adds center and brush offset.
// ----------------------------------------------------------------------------
module tcr_pixel_calc import tcr_pkg::*; (
	input  walk_state_t               st,
	output logic signed [COORD_W-1:0] pixel_x,
	output logic signed [COORD_W-1:0] pixel_y
);

	logic        [STEP_W-1:0] mag_x;
	logic        [STEP_W-1:0] mag_y;
	logic signed [SUM_W-1:0]  dx;
	logic signed [SUM_W-1:0]  dy;
	logic signed [SUM_W-1:0]  sum_x;
	logic signed [SUM_W-1:0]  sum_y;

	always_comb begin
		mag_x = st.octant[2] ? st.step_y : st.step_x;
		mag_y = st.octant[2] ? st.step_x : st.step_y;
		dx = $signed({{(SUM_W-STEP_W){1'b0}}, mag_x});
		dy = $signed({{(SUM_W-STEP_W){1'b0}}, mag_y});
		if (st.octant[0]) begin
			dx = -dx;
		end
		if (st.octant[1]) begin
			dy = -dy;
		end
		sum_x = SUM_W'(st.center_x) + dx + SUM_W'(st.offset_i);
		sum_y = SUM_W'(st.center_y) + dy + SUM_W'(st.offset_j);
		pixel_x = sum_x[COORD_W-1:0];
		pixel_y = sum_y[COORD_W-1:0];
	end

endmodule

>>> design/thick_circle_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle rasterizer
// Midpoint circle walker with a square brush, one pixel per advance command.
// ----------------------------------------------------------------------------
// A start command latches center, radius, brush half-size and color and emits
// nothing; each following advance command emits one pixel, and the pixel that
// closes the circle carries last. For every command, start or advance, the
// walker state is updated and the pixel registered in the cycle of the
// transfer, and the output register frees itself in the cycle it is taken,
// so a command can be accepted in every cycle while the output keeps pace.
// A circle of radius r and brush half-size b yields 8*(2b+1)^2 pixels per
// midpoint step. Advance commands sent while no circle is active are dropped.
// The opacity register is sampled into each pixel as it is produced.
// ----------------------------------------------------------------------------
module thick_circle_rasterizer import tcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	tcr_item_if.sink           item,
	tcr_pixel_if.source        pixel,
	input  logic               opacity_we,
	input  logic [ALPHA_W-1:0] opacity_wdata
);

	walk_state_t               st_q;
	logic                      active_q;
	logic signed [DEC_W-1:0]   decision_q;
	logic        [BRUSH_BITS-1:0] brush_q;
	logic        [COLOR_W-1:0] col_r_q;
	logic        [COLOR_W-1:0] col_g_q;
	logic        [COLOR_W-1:0] col_b_q;
	logic        [ALPHA_W-1:0] opacity_q;

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] out_x_q;
	logic signed [COORD_W-1:0] out_y_q;
	logic        [COLOR_W-1:0] out_r_q;
	logic        [COLOR_W-1:0] out_g_q;
	logic        [COLOR_W-1:0] out_b_q;
	logic        [ALPHA_W-1:0] out_alpha_q;
	logic                      out_last_q;

	logic                      accept;
	logic                      emit;
	logic signed [COORD_W-1:0] calc_x;
	logic signed [COORD_W-1:0] calc_y;

	logic signed [OFS_W-1:0]   brush_pos;
	logic signed [OFS_W-1:0]   brush_neg;
	logic signed [OFS_W-1:0]   new_brush_neg;
	logic        [RADIUS_BITS-1:0] new_radius;
	logic        [STEP_W-1:0]  next_x;
	logic        [STEP_W-1:0]  next_y;
	logic signed [DEC_W-1:0]   next_d;
	logic signed [STEP_W:0]    x_minus_y;
	logic                      step_done;
	logic                      circle_done;

	tcr_pixel_calc u_pixel_calc (
		.st      (st_q),
		.pixel_x (calc_x),
		.pixel_y (calc_y)
	);

	assign item.ready = !out_valid_q || pixel.ready;
	assign accept     = item.valid && item.ready;
	assign emit       = accept && (item.cmd == CMD_ADVANCE) && active_q;

	always_comb begin
		brush_pos     = $signed({1'b0, brush_q});
		brush_neg     = -brush_pos;
		new_brush_neg = -$signed({1'b0, item.brush_half[BRUSH_BITS-1:0]});
		new_radius    = item.radius[RADIUS_BITS-1:0];
		step_done     = (st_q.octant == 3'd7) && (st_q.offset_j == brush_pos)
			&& (st_q.offset_i == brush_pos);
		x_minus_y     = $signed({1'b0, st_q.step_x}) - $signed({1'b0, st_q.step_y});
		if (decision_q < 0) begin
			next_d = decision_q + $signed({{(DEC_W-STEP_W-2){1'b0}}, st_q.step_x, 2'b00})
				+ DEC_W'(6);
			next_y = st_q.step_y;
		end else begin
			next_d = decision_q + $signed({{(DEC_W-STEP_W-3){x_minus_y[STEP_W]}},
				x_minus_y, 2'b00}) + DEC_W'(10);
			next_y = st_q.step_y - STEP_W'(1);
		end
		next_x      = st_q.step_x + STEP_W'(1);
		circle_done = step_done && ((next_x > next_y) || (st_q.step_y == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= OPACITY_RESET;
		end else if (opacity_we) begin
			opacity_q <= opacity_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			st_q       <= '0;
			decision_q <= '0;
			brush_q    <= '0;
			col_r_q    <= '0;
			col_g_q    <= '0;
			col_b_q    <= '0;
		end else if (accept) begin
			if (item.cmd == CMD_START) begin
				active_q        <= 1'b1;
				st_q.step_x     <= '0;
				st_q.step_y     <= STEP_W'(new_radius);
				decision_q      <= DEC_W'(3) - $signed({{(DEC_W-RADIUS_BITS-1){1'b0}},
					new_radius, 1'b0});
				st_q.offset_i   <= new_brush_neg;
				st_q.offset_j   <= new_brush_neg;
				st_q.octant     <= '0;
				st_q.center_x   <= item.center_x;
				st_q.center_y   <= item.center_y;
				brush_q         <= item.brush_half[BRUSH_BITS-1:0];
				col_r_q         <= item.color_r;
				col_g_q         <= item.color_g;
				col_b_q         <= item.color_b;
			end else if (active_q) begin
				st_q.octant <= st_q.octant + 3'd1;
				if (st_q.octant == 3'd7) begin
					if (st_q.offset_j < brush_pos) begin
						st_q.offset_j <= st_q.offset_j + OFS_W'(1);
					end else begin
						st_q.offset_j <= brush_neg;
						if (st_q.offset_i < brush_pos) begin
							st_q.offset_i <= st_q.offset_i + OFS_W'(1);
						end else begin
							st_q.offset_i <= brush_neg;
							decision_q    <= next_d;
							st_q.step_x   <= next_x;
							st_q.step_y   <= next_y;
							if (circle_done) begin
								active_q <= 1'b0;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || pixel.ready) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= calc_x;
			out_y_q     <= calc_y;
			out_r_q     <= col_r_q;
			out_g_q     <= col_g_q;
			out_b_q     <= col_b_q;
			out_alpha_q <= opacity_q;
			out_last_q  <= circle_done;
		end
	end

	assign pixel.valid     = out_valid_q;
	assign pixel.pixel_x   = out_x_q;
	assign pixel.pixel_y   = out_y_q;
	assign pixel.pix_r     = out_r_q;
	assign pixel.pix_g     = out_g_q;
	assign pixel.pix_b     = out_b_q;
	assign pixel.pix_alpha = out_alpha_q;
	assign pixel.last      = out_last_q;

endmodule
